// File: rtl/nvpt_pkg.sv
package nvpt_pkg;

   // Name storage sizing: a name keeps at most NAME_LEN-1 bytes.
   localparam int NAME_LEN  = 28;
   localparam int KEEP_MAX  = NAME_LEN - 1;
   localparam int ADDR_W    = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
   localparam int LEN_W     = $clog2(KEEP_MAX + 1);
   localparam int MEM_DEPTH = 2 * (2 ** ADDR_W);

   localparam logic [LEN_W-1:0] KEEP_MAX_L = LEN_W'(KEEP_MAX);

   // Command queue between the classifier and the pair engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Character codes the classifier reacts to.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   // Command kinds passed from the front to the back.
   localparam logic [1:0] CMD_CHAR        = 2'd0;
   localparam logic [1:0] CMD_SEP         = 2'd1;
   localparam logic [1:0] CMD_END_COMMENT = 2'd2;
   localparam logic [1:0] CMD_FAIL        = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic       failed;
      logic       is_value;
      logic [7:0] name_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

endpackage

// File: rtl/nvpt_front.sv
module nvpt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nvpt_pkg::req_type req_data,
   input  logic              queue_full,
   output nvpt_pkg::push_type push
);

   logic in_comment_ff;
   logic in_comment_in;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify each accepted byte into a command for the pair engine.
   always_comb begin
      in_comment_in       = in_comment_ff;
      push.valid          = 1'b0;
      push.cmd.kind       = nvpt_pkg::CMD_CHAR;
      push.cmd.data_byte  = req_data.data_byte;
      if (accept) begin
         if (req_data.end_of_input) begin
            push.valid    = 1'b1;
            push.cmd.kind = in_comment_ff ? nvpt_pkg::CMD_END_COMMENT : nvpt_pkg::CMD_FAIL;
            in_comment_in = 1'b0;
         end else if (in_comment_ff) begin
            // Comment bytes are swallowed; the newline closes the comment and the name.
            if (req_data.data_byte == nvpt_pkg::CH_NL) begin
               push.valid    = 1'b1;
               push.cmd.kind = nvpt_pkg::CMD_SEP;
               in_comment_in = 1'b0;
            end
         end else begin
            case (req_data.data_byte)
               nvpt_pkg::CH_NUL: begin
                  push.valid    = 1'b1;
                  push.cmd.kind = nvpt_pkg::CMD_FAIL;
               end
               nvpt_pkg::CH_HASH: begin
                  in_comment_in = 1'b1;
               end
               nvpt_pkg::CH_SPACE, nvpt_pkg::CH_TAB, nvpt_pkg::CH_NL,
               nvpt_pkg::CH_COLON, nvpt_pkg::CH_COMMA, nvpt_pkg::CH_EQUALS: begin
                  push.valid    = 1'b1;
                  push.cmd.kind = nvpt_pkg::CMD_SEP;
               end
               default: begin
                  push.valid    = 1'b1;
                  push.cmd.kind = nvpt_pkg::CMD_CHAR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
      end else begin
         in_comment_ff <= in_comment_in;
      end
   end

endmodule

// File: rtl/nvpt_queue.sv
module nvpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  nvpt_pkg::push_type push,
   output logic               full,
   input  logic               pop,
   output logic               out_valid,
   output nvpt_pkg::cmd_type  out_cmd
);

   nvpt_pkg::cmd_type               entries_ff [nvpt_pkg::QUEUE_DEPTH];
   logic [nvpt_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [nvpt_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [nvpt_pkg::QPTR_W:0]       count_ff;
   logic                            push_do;
   logic                            pop_do;

   assign full      = (count_ff == (nvpt_pkg::QPTR_W + 1)'(nvpt_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entries_ff[rd_ptr_ff];
   assign push_do   = push.valid && !full;
   assign pop_do    = pop && out_valid;

   // Entry storage needs no reset; only the pointers and count do.
   always_ff @(posedge clock) begin
      if (push_do) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_do) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_do) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + {{nvpt_pkg::QPTR_W{1'b0}}, push_do}
                              - {{nvpt_pkg::QPTR_W{1'b0}}, pop_do};
      end
   end

endmodule

// File: rtl/nvpt_back.sv
module nvpt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  nvpt_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nvpt_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   localparam logic [1:0] PH_KEY   = 2'd0;
   localparam logic [1:0] PH_SEEN  = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   logic [1:0]                 state_ff,    state_in;
   logic [1:0]                 phase_ff,    phase_in;
   logic [nvpt_pkg::LEN_W-1:0] cand_len_ff, cand_len_in;
   logic [nvpt_pkg::LEN_W-1:0] key_len_ff,  key_len_in;
   logic [nvpt_pkg::LEN_W-1:0] val_len_ff,  val_len_in;
   logic [nvpt_pkg::LEN_W-1:0] idx_ff,      idx_in;
   logic                       cand_bank_ff, cand_bank_in;
   logic                       in_value_ff, in_value_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   nvpt_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic [7:0]                 rd_data_ff;
   logic [7:0]                 name_mem [nvpt_pkg::MEM_DEPTH];

   logic                        slot_free;
   logic                        wr_en;
   logic [nvpt_pkg::ADDR_W:0]   wr_addr;
   logic [nvpt_pkg::ADDR_W:0]   rd_addr;
   logic                        do_end_name;
   logic                        do_fail;
   logic                        is_eq;
   logic                        last_byte;
   logic                        key_end;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && slot_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Two banks: the candidate name is built in one, the key sits in the other.
   assign wr_addr = {cand_bank_ff, cand_len_ff[nvpt_pkg::ADDR_W-1:0]};
   assign rd_addr = {in_value_ff ? cand_bank_ff : ~cand_bank_ff,
                     idx_ff[nvpt_pkg::ADDR_W-1:0]};

   assign is_eq     = (cmd.kind == nvpt_pkg::CMD_SEP) && (cmd.data_byte == nvpt_pkg::CH_EQUALS);
   assign last_byte = in_value_ff && (idx_ff == val_len_ff - nvpt_pkg::LEN_W'(1));
   assign key_end   = !in_value_ff && (idx_ff == key_len_ff - nvpt_pkg::LEN_W'(1));

   // Command execution, pair state and byte-by-byte emission.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cand_len_in  = cand_len_ff;
      key_len_in   = key_len_ff;
      val_len_in   = val_len_ff;
      idx_in       = idx_ff;
      cand_bank_in = cand_bank_ff;
      in_value_in  = in_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      do_end_name  = 1'b0;
      do_fail      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd.kind)
                  nvpt_pkg::CMD_CHAR: begin
                     if (cand_len_ff < nvpt_pkg::KEEP_MAX_L) begin
                        wr_en       = 1'b1;
                        cand_len_in = cand_len_ff + nvpt_pkg::LEN_W'(1);
                     end
                  end
                  nvpt_pkg::CMD_SEP: begin
                     do_end_name = 1'b1;
                  end
                  nvpt_pkg::CMD_END_COMMENT: begin
                     if (phase_ff[1] && (cand_len_ff != '0)) begin
                        do_end_name = 1'b1;
                     end else begin
                        do_fail = 1'b1;
                     end
                  end
                  default: begin
                     do_fail = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.failed    = 1'b0;
               rsp_data_in.is_value  = in_value_ff;
               rsp_data_in.name_byte = rd_data_ff;
               rsp_data_in.last      = last_byte;
               if (last_byte) begin
                  state_in    = ST_IDLE;
                  phase_in    = PH_KEY;
                  key_len_in  = '0;
                  val_len_in  = '0;
                  cand_len_in = '0;
               end else begin
                  state_in = ST_READ;
                  if (key_end) begin
                     in_value_in = 1'b1;
                     idx_in      = '0;
                  end else begin
                     idx_in = idx_ff + nvpt_pkg::LEN_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A name has ended: promote it to key, or start emitting the pair.
      if (do_end_name) begin
         cand_len_in = '0;
         if (!phase_ff[1]) begin
            if (cand_len_ff != '0) begin
               cand_bank_in = ~cand_bank_ff;
               key_len_in   = cand_len_ff;
            end
            if ((cand_len_ff != '0) || (phase_ff == PH_SEEN)) begin
               phase_in = is_eq ? PH_VALUE : PH_SEEN;
            end
         end else if (cand_len_ff != '0) begin
            val_len_in  = cand_len_ff;
            idx_in      = '0;
            in_value_in = 1'b0;
            state_in    = ST_READ;
         end
      end

      // A failure gives one result and clears the pair state.
      if (do_fail) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.failed    = 1'b1;
         rsp_data_in.is_value  = 1'b0;
         rsp_data_in.name_byte = '0;
         rsp_data_in.last      = 1'b1;
         phase_in              = PH_KEY;
         cand_len_in           = '0;
         key_len_in            = '0;
         val_len_in            = '0;
      end
   end

   // Name storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= cmd.data_byte;
      end
      rd_data_ff <= name_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_KEY;
         cand_len_ff  <= '0;
         key_len_ff   <= '0;
         val_len_ff   <= '0;
         idx_ff       <= '0;
         cand_bank_ff <= 1'b0;
         in_value_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cand_len_ff  <= cand_len_in;
         key_len_ff   <= key_len_in;
         val_len_ff   <= val_len_in;
         idx_ff       <= idx_in;
         cand_bank_ff <= cand_bank_in;
         in_value_ff  <= in_value_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/name_value_pair_tokenizer.sv
// Channel   Direction  Payload              Transfer when
// req_      in         nvpt_pkg::req_type   req_valid && req_ready
// rsp_      out        nvpt_pkg::rsp_type   rsp_valid && rsp_ready
//
// A byte is taken every cycle while the four-entry command queue has room.
// Each pair byte passes through the pair engine as a registered name memory
// read followed by a load of the output register; a failure loads it directly.
// Reset is synchronous and clears control state only; no clearing pass runs.
// Input and output stall independently through the command queue.
module name_value_pair_tokenizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nvpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nvpt_pkg::rsp_type rsp_data
);

   nvpt_pkg::push_type push;
   nvpt_pkg::cmd_type  queue_cmd;
   logic               queue_full;
   logic               queue_valid;
   logic               queue_pop;

   // Byte classifier and comment tracking.
   nvpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   // Command queue decoupling input from emission.
   nvpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop       (queue_pop),
      .out_valid (queue_valid),
      .out_cmd   (queue_cmd)
   );

   // Pair engine: name storage, pair state and result emission.
   nvpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/nvpt_checker.sv
module nvpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input nvpt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input nvpt_pkg::rsp_type rsp_data
);

   // A waiting input transfer keeps its byte until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input changed while waiting");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A failure result is a single, empty, final item.
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |->
         rsp_data.last && !rsp_data.is_value && (rsp_data.name_byte == 8'h00))
      else $error("malformed failure result");

   // A pair always ends on a value byte, so a key byte is never last.
   a_key_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.failed && !rsp_data.is_value |-> !rsp_data.last)
      else $error("key byte marked last");

   // No result is offered straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind name_value_pair_tokenizer nvpt_checker u_checker (.*);
